/* hdl/sdc_pkg.sv */
package sdc_pkg;

  localparam int SLOTS       = 64;
  localparam int SLOT_W      = 6;
  localparam int ADDR_W      = 31;
  localparam int LEN_W       = 10;
  localparam int OFF_W       = 9;
  localparam int TAG_W       = 32;
  localparam int BLOCK_BYTES = 512;
  localparam int CNT_W       = $clog2(SLOTS);

  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // one entry of the address-ordered used chain
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] base;
    logic [TAG_W-1:0]  tag;
  } uent_t;

  // one entry of the free chain, head at cell zero
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
  } fent_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  offset;
    logic              fetch;
    logic [ADDR_W-1:0] faddr;
    logic              no_free;
  } res_t;

  typedef enum logic [1:0] {
    UOP_HOLD,
    UOP_ROT,
    UOP_PACK
  } uop_t;

  typedef enum logic [1:0] {
    FOP_HOLD,
    FOP_LEFT,
    FOP_RIGHT
  } fop_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PACK,
    ST_DONE
  } state_t;

endpackage

/* hdl/sdc_ucell.sv */
module sdc_ucell (
  input  logic           clk,
  input  logic           rst_n,
  input  sdc_pkg::uop_t  op,
  input  sdc_pkg::uent_t right,
  input  logic           pull_in,
  output logic           pull_out,
  output sdc_pkg::uent_t q
);
  import sdc_pkg::*;

  uent_t q_r, q_nxt;

  // a hole here or to the left pulls the right neighbor in while packing
  assign pull_out = pull_in | ~q_r.vld;
  assign q        = q_r;

  always_comb begin
    q_nxt = q_r;
    case (op)
      UOP_ROT:  q_nxt = right;
      UOP_PACK: begin
        if (pull_out) begin
          q_nxt = right;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

endmodule

/* hdl/sdc_fcell.sv */
module sdc_fcell (
  input  logic           clk,
  input  logic           rst_n,
  input  sdc_pkg::fop_t  op,
  input  sdc_pkg::fent_t left,
  input  sdc_pkg::fent_t right,
  input  sdc_pkg::fent_t rst_val,
  output sdc_pkg::fent_t q
);
  import sdc_pkg::*;

  fent_t q_r, q_nxt;

  assign q = q_r;

  // shift toward the head on a pop, away from it on a push
  always_comb begin
    q_nxt = q_r;
    case (op)
      FOP_LEFT:  q_nxt = left;
      FOP_RIGHT: q_nxt = right;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= rst_val;
    end else begin
      q_r <= q_nxt;
    end
  end

endmodule

/* hdl/sample_dma_block_cache_top.sv */
// request: one pass of the used chain (64 rotation steps), then the result
// is loaded into the output register once that register is free
// frame tick: a 64-step rotation pass then 64 packing steps
// one item at a time; a new input beat is taken while a result still waits
// synchronous active-low reset: all slots free in index order, frame count zero
module sample_dma_block_cache_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [sdc_pkg::ADDR_W-1:0] in_address,
  input  logic [sdc_pkg::LEN_W-1:0]  in_length,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [sdc_pkg::SLOT_W-1:0] out_slot,
  output logic [sdc_pkg::OFF_W-1:0]  out_offset,
  output logic                       out_fetch,
  output logic [sdc_pkg::ADDR_W-1:0] out_fetch_address,
  output logic                       out_no_free
);
  import sdc_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  uent_t             hold_r, hold_nxt;
  res_t              res_r, res_nxt;
  res_t              out_r, out_nxt;
  logic              ov_r, ov_nxt;
  logic [SLOT_W-1:0] uhead_r, uhead_nxt;
  logic [TAG_W-1:0]  fc_r, fc_nxt;
  logic              kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;

  uop_t              uop;
  uent_t             tail;
  logic              fpop, fpush;
  fent_t             push_item;
  logic              accept;

  uent_t             u_q [SLOTS];
  uent_t             u_right [SLOTS];
  logic              pull [SLOTS+1];
  fent_t             f_q [SLOTS];
  fent_t             f_left [SLOTS];
  fent_t             f_right [SLOTS];
  fop_t              f_op [SLOTS];

  uent_t             x;
  fent_t             fh;
  logic [ADDR_W:0]   req_end, blk_end;
  logic [ADDR_W-1:0] off_full;
  logic [TAG_W-1:0]  tag_inc;

  assign x        = u_q[0];
  assign fh       = f_q[0];
  assign req_end  = {1'b0, addr_r} + (ADDR_W+1)'(len_r);
  assign blk_end  = {1'b0, x.base} + (ADDR_W+1)'(BLOCK_BYTES);
  assign off_full = addr_r - x.base;
  assign tag_inc  = x.tag + TAG_W'(1);
  assign accept   = in_valid & in_ready;
  assign pull[0]  = 1'b0;

  // used chain: rotates through the scan point, packs out holes after a tick
  for (genvar k = 0; k < SLOTS; k++) begin : g_used
    if (k == SLOTS-1) begin : g_last
      assign u_right[k] = tail;
    end else begin : g_mid
      assign u_right[k] = u_q[k+1];
    end
    sdc_ucell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (uop),
      .right    (u_right[k]),
      .pull_in  (pull[k]),
      .pull_out (pull[k+1]),
      .q        (u_q[k])
    );
  end

  // free chain: pop from the head, push right behind the head (into the head when empty)
  for (genvar k = 0; k < SLOTS; k++) begin : g_free
    if (k == SLOTS-1) begin : g_last
      assign f_right[k] = '0;
    end else begin : g_mid
      assign f_right[k] = f_q[k+1];
    end
    if (k < 2) begin : g_near
      assign f_left[k] = push_item;
    end else begin : g_far
      assign f_left[k] = f_q[k-1];
    end
    always_comb begin
      f_op[k] = FOP_HOLD;
      if (fpop) begin
        f_op[k] = FOP_RIGHT;
      end else if (fpush) begin
        if (fh.vld) begin
          f_op[k] = (k == 0) ? FOP_HOLD : FOP_LEFT;
        end else begin
          f_op[k] = (k == 0) ? FOP_LEFT : FOP_HOLD;
        end
      end
    end
    sdc_fcell f_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (f_op[k]),
      .left    (f_left[k]),
      .right   (f_right[k]),
      .rst_val ('{vld: 1'b1, slot: SLOT_W'(k)}),
      .q       (f_q[k])
    );
  end

  // sequencer and scan point
  always_comb begin
    logic [SLOT_W-1:0] uh;
    uh        = (cnt_r == '0) ? (x.vld ? x.slot : '0) : uhead_r;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    hold_nxt  = hold_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r & ~out_ready;
    uhead_nxt = uhead_r;
    fc_nxt    = fc_r;
    uop       = UOP_HOLD;
    tail      = '0;
    fpop      = 1'b0;
    fpush     = 1'b0;
    push_item = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt   = '0;
          done_nxt  = 1'b0;
          hold_nxt  = '0;
          res_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        uop     = UOP_ROT;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (kind_r == KIND_TICK) begin
          // stale buffers leave the used chain and go behind the free head
          if (x.vld && (tag_inc < fc_r)) begin
            fpush     = 1'b1;
            push_item = '{vld: 1'b1, slot: x.slot};
          end else begin
            tail = x;
          end
        end else begin
          uhead_nxt = uh;
          if (hold_r.vld) begin
            // shifting the rest of the chain down one place after an insert
            tail     = hold_r;
            hold_nxt = x;
          end else if (done_r) begin
            tail = x;
          end else if (x.vld && (x.base <= addr_r)) begin
            tail = x;
            if (req_end <= blk_end) begin
              tail.tag       = fc_r;
              done_nxt       = 1'b1;
              res_nxt.hit    = 1'b1;
              res_nxt.slot   = x.slot;
              res_nxt.offset = off_full[OFF_W-1:0];
            end
          end else begin
            // insertion point: end of chain or first base above the address
            done_nxt = 1'b1;
            if (fh.vld) begin
              fpop           = 1'b1;
              tail           = '{vld: 1'b1, slot: fh.slot,
                                 base: {addr_r[ADDR_W-1:1], 1'b0}, tag: fc_r};
              hold_nxt       = x;
              res_nxt.fetch  = 1'b1;
              res_nxt.slot   = fh.slot;
              res_nxt.offset = OFF_W'(addr_r[0]);
              res_nxt.faddr  = {addr_r[ADDR_W-1:1], 1'b0};
            end else begin
              tail            = x;
              res_nxt.no_free = 1'b1;
              res_nxt.slot    = uh;
            end
          end
          // full chain with every base at or below the address
          if ((cnt_r == CNT_W'(SLOTS-1)) && !done_nxt) begin
            done_nxt        = 1'b1;
            res_nxt.no_free = 1'b1;
            res_nxt.slot    = uh;
          end
        end
        if (cnt_r == CNT_W'(SLOTS-1)) begin
          state_nxt = (kind_r == KIND_TICK) ? ST_PACK : ST_DONE;
        end
      end
      ST_PACK: begin
        uop     = UOP_PACK;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SLOTS-1)) begin
          fc_nxt    = fc_r + TAG_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          out_nxt   = res_r;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      hold_r  <= '0;
      ov_r    <= 1'b0;
      uhead_r <= '0;
      fc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      hold_r  <= hold_nxt;
      ov_r    <= ov_nxt;
      uhead_r <= uhead_nxt;
      fc_r    <= fc_nxt;
    end
  end

  // beat payload and result registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
    if (accept) begin
      kind_r <= in_kind;
      addr_r <= in_address;
      len_r  <= in_length;
    end
  end

  assign out_valid         = ov_r;
  assign out_hit           = out_r.hit;
  assign out_slot          = out_r.slot;
  assign out_offset        = out_r.offset;
  assign out_fetch         = out_r.fetch;
  assign out_fetch_address = out_r.faddr;
  assign out_no_free       = out_r.no_free;

endmodule

/* tb/sample_dma_block_cache_top_tb.sv */
`timescale 1ns / 1ps

module sample_dma_block_cache_top_tb;
  import sdc_pkg::*;

  localparam int NIL = 127;
  localparam int N_RAND = 1600;
  localparam int WATCHDOG = 20000;

  // expected beat on the result side
  typedef struct {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  offset;
    logic              fetch;
    logic [ADDR_W-1:0] faddr;
    logic              no_free;
  } cache_res_t;

  // behavioral copy of the buffer pool and its expected results
  class cache_scoreboard;
    bit [30:0] base_of[SLOTS];
    bit [31:0] tag_of[SLOTS];
    int        nxt[SLOTS];
    int        prv[SLOTS];
    int        used_hd;
    int        free_hd;
    bit [31:0] frame_cnt;
    cache_res_t pending[$];
    int        errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        base_of[i] = 0;
        tag_of[i] = 0;
        nxt[i] = (i + 1 < SLOTS) ? i + 1 : NIL;
        prv[i] = NIL;
      end
      used_hd = NIL;
      free_hd = 0;
      frame_cnt = 0;
      errors = 0;
    endfunction

    function void unhook(int e);
      if (prv[e] != NIL) nxt[prv[e]] = nxt[e];
      if (nxt[e] != NIL) prv[nxt[e]] = prv[e];
    endfunction

    function void hook_after(int e, int a);
      nxt[e] = nxt[a];
      prv[e] = a;
      if (nxt[a] != NIL) prv[nxt[a]] = e;
      nxt[a] = e;
    endfunction

    // note one accepted input beat and queue its result
    function void note_input(logic kind, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
      cache_res_t r;
      int e, n, prior;
      bit found;
      longint a, b;
      r = '{default: 0};
      if (kind == KIND_TICK) begin
        // return stale buffers right after the free head
        e = used_hd;
        while (e != NIL) begin
          n = nxt[e];
          if (32'(tag_of[e] + 32'd1) < frame_cnt) begin
            if (e == used_hd) used_hd = n;
            unhook(e);
            if (free_hd != NIL) hook_after(e, free_hd);
            else begin
              free_hd = e;
              nxt[e] = NIL;
              prv[e] = NIL;
            end
          end
          e = n;
        end
        frame_cnt++;
      end else begin
        found = 0;
        prior = NIL;
        a = addr;
        e = used_hd;
        while (e != NIL) begin
          b = base_of[e];
          if (b > a) break;
          prior = e;
          if (a + len <= b + BLOCK_BYTES) begin
            tag_of[e] = frame_cnt;
            r.hit = 1;
            r.slot = e[SLOT_W-1:0];
            r.offset = OFF_W'(a - b);
            found = 1;
            break;
          end
          e = nxt[e];
        end
        if (!found) begin
          e = free_hd;
          if (e == NIL) begin
            r.no_free = 1;
            r.slot = (used_hd != NIL) ? used_hd[SLOT_W-1:0] : '0;
          end else begin
            free_hd = nxt[e];
            unhook(e);
            if (prior != NIL) hook_after(e, prior);
            else begin
              nxt[e] = used_hd;
              prv[e] = NIL;
              if (used_hd != NIL) prv[used_hd] = e;
              used_hd = e;
            end
            base_of[e] = {addr[ADDR_W-1:1], 1'b0};
            tag_of[e] = frame_cnt;
            r.fetch = 1;
            r.faddr = {addr[ADDR_W-1:1], 1'b0};
            r.slot = e[SLOT_W-1:0];
            r.offset = OFF_W'(addr[0]);
          end
        end
      end
      pending.push_back(r);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(cache_res_t got);
      cache_res_t x;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.hit !== x.hit) begin
        $error("hit exp %0d got %0d", x.hit, got.hit); errors++;
      end
      if (got.slot !== x.slot) begin
        $error("slot exp %0d got %0d", x.slot, got.slot); errors++;
      end
      if (got.offset !== x.offset) begin
        $error("offset exp %0d got %0d", x.offset, got.offset); errors++;
      end
      if (got.fetch !== x.fetch) begin
        $error("fetch exp %0d got %0d", x.fetch, got.fetch); errors++;
      end
      if (got.faddr !== x.faddr) begin
        $error("fetch_address exp %h got %h", x.faddr, got.faddr); errors++;
      end
      if (got.no_free !== x.no_free) begin
        $error("no_free exp %0d got %0d", x.no_free, got.no_free); errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_kind;
  logic [ADDR_W-1:0]   in_address;
  logic [LEN_W-1:0]    in_length;
  logic                out_valid;
  logic                out_ready;
  logic                out_hit;
  logic [SLOT_W-1:0]   out_slot;
  logic [OFF_W-1:0]    out_offset;
  logic                out_fetch;
  logic [ADDR_W-1:0]   out_fetch_address;
  logic                out_no_free;

  cache_scoreboard sb;
  bit  hold_off;
  int  idle_cycles;
  logic [ADDR_W-1:0] hot_base;

  sample_dma_block_cache_top dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  // send one beat and hold it until accepted; valid drops only before a gap
  task automatic send_beat(logic kind, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_kind <= kind;
    in_address <= addr;
    in_length <= len;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_req(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
    send_beat(KIND_REQ, addr, len);
  endtask

  // input acceptance feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_kind, in_address, in_length);
  end

  // result acceptance feeds the checker
  always @(posedge clk) begin
    cache_res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.hit = out_hit;
      got.slot = out_slot;
      got.offset = out_offset;
      got.fetch = out_fetch;
      got.faddr = out_fetch_address;
      got.no_free = out_no_free;
      sb.check_result(got);
    end
  end

  // receiver stalls at random, plus one long hold-off
  initial begin
    int g;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        hold_off = 0;
        out_ready <= 1;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(negedge clk);
        end
        out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int p;
    logic [ADDR_W-1:0] a;
    sb = new();
    hold_off = 0;
    idle_cycles = 0;
    in_valid = 0;
    in_kind = 0;
    in_address = 0;
    in_length = 0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, hits at block end, fill to no-free, ticks
    send_req(31'h0, 10'd0);
    send_req(31'h0, 10'd512);
    send_req(31'd512, 10'd0);
    send_req(31'h7FFF_FFFF, 10'd1023);
    send_req(31'h7FFF_FFFF, 10'd0);
    send_req(31'h7FFF_FE00, 10'd512);
    send_req(31'd101, 10'd3);
    send_req(31'd100, 10'd512);
    send_req(31'd612, 10'd0);
    send_req(31'h2AAA_AAAB, 10'h155);
    send_req(31'h5555_5554, 10'h2AA);
    send_beat(KIND_TICK, 31'h7FFF_FFFF, 10'h3FF);
    send_beat(KIND_TICK, 31'h0, 10'h0);
    send_beat(KIND_TICK, 31'h0, 10'h0);
    // fill all slots and overflow
    for (int i = 0; i < 70; i++) send_req(31'(i * 4096 + 31'h100000), 10'd8);
    send_beat(KIND_TICK, 31'h0, 10'h0);
    send_beat(KIND_TICK, 31'h0, 10'h0);
    send_beat(KIND_TICK, 31'h0, 10'h0);

    // random: mostly requests near a wandering working set
    hot_base = 31'h0010_0000;
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 400) hold_off = 1;
      p = $urandom_range(0, 99);
      if (p < 6) send_beat(KIND_TICK, 31'($urandom), 10'($urandom));
      else if (p < 70) begin
        a = hot_base + 31'($urandom_range(0, 64 * 1024));
        send_req(a, 10'($urandom_range(0, 512)));
      end else if (p < 85) begin
        send_req(31'($urandom), 10'($urandom));
      end else begin
        if ($urandom_range(0, 19) == 0) hot_base = 31'($urandom);
        send_req(hot_base, 10'($urandom_range(0, 1023)));
      end
    end
    @(negedge clk);
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
hdl/sdc_pkg.sv
hdl/sdc_ucell.sv
hdl/sdc_fcell.sv
hdl/sample_dma_block_cache_top.sv
tb/sample_dma_block_cache_top_tb.sv
